[rtl/kpd_pkg.sv]
// ----------------------------------------------------------------------------
// kpd_pkg: keypad event detector package
// Shared widths, reset values and lane/knob status types.
// ----------------------------------------------------------------------------
package kpd_pkg;

	localparam int KEY_W      = 12;
	localparam int NUM_KEYS   = 12;
	localparam int TIME_W     = 32;
	localparam int LP_W       = 16;

	localparam logic [LP_W-1:0] LONG_PRESS_RST = LP_W'(1000);

	typedef struct packed {
		logic held;
		logic pressed;
		logic released;
	} kpd_key_evt_t;

	typedef struct packed {
		logic short_press;
		logic long_press;
	} kpd_knob_evt_t;

	typedef struct packed {
		logic [KEY_W-1:0] keys_held;
		logic [KEY_W-1:0] keys_pressed;
		logic [KEY_W-1:0] keys_released;
		logic             short_press;
		logic             long_press;
	} kpd_result_t;

endpackage

[rtl/kpd_if.sv]
// ----------------------------------------------------------------------------
// kpd_if: keypad event detector channels
// Scan input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface kpd_scan_if import kpd_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  key_levels;
	logic              knob_level;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, output key_levels, output knob_level, output now_ms,
		input ready);
	modport sink (input valid, input key_levels, input knob_level, input now_ms,
		output ready);
endinterface

interface kpd_result_if import kpd_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] keys_held;
	logic [KEY_W-1:0] keys_pressed;
	logic [KEY_W-1:0] keys_released;
	logic             short_press;
	logic             long_press;

	modport source (output valid, output keys_held, output keys_pressed,
		output keys_released, output short_press, output long_press, input ready);
	modport sink (input valid, input keys_held, input keys_pressed,
		input keys_released, input short_press, input long_press, output ready);
endinterface

[rtl/kpd_key_lane.sv]
// ----------------------------------------------------------------------------
// kpd_key_lane: single key edge lane
// Holds the previous level of one key and flags held, press and release.
// ----------------------------------------------------------------------------
module kpd_key_lane import kpd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         level,
	output kpd_key_evt_t evt
);

	logic prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b1;
		end else if (en) begin
			prev_q <= level;
		end
	end

	always_comb begin
		evt.held     = ~level;
		evt.pressed  = ~level & prev_q;
		evt.released = level & ~prev_q;
	end

endmodule

[rtl/kpd_knob.sv]
// ----------------------------------------------------------------------------
// kpd_knob: knob press timer
// Arms on a falling edge, flags a long press after the hold time, else a
// short press on release.
// ----------------------------------------------------------------------------
module kpd_knob import kpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              knob_level,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [LP_W-1:0]   long_press_ms,
	output kpd_knob_evt_t     evt
);

	logic              prev_q;
	logic              armed_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] elapsed;
	logic              fall;

	assign fall    = ~knob_level & prev_q;
	assign elapsed = now_ms - start_q;

	always_comb begin
		evt.long_press  = ~knob_level & ~prev_q & armed_q &
			(elapsed >= {{(TIME_W-LP_W){1'b0}}, long_press_ms});
		evt.short_press = knob_level & ~prev_q & armed_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b1;
			armed_q <= 1'b0;
			start_q <= '0;
		end else if (en) begin
			prev_q <= knob_level;
			if (fall) begin
				start_q <= now_ms;
				armed_q <= 1'b1;
			end else if (evt.long_press || evt.short_press) begin
				armed_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/keypad_event_detector.sv]
// Path: a transferred scan's result goes into out_q, or into skid_q and then
// out_q when the output stalls. Throughput: one scan per cycle while the skid
// register is empty, and that one-entry register absorbs one stalled result.
// Reset: all keys and the knob read as released, the press timer is disarmed,
// long_press_ms returns to 1000 and both output stages are empty.
// ----------------------------------------------------------------------------
// keypad_event_detector: keypad and knob event detector
// Parallel key edge lanes and a knob timer, merged into a result register with a skid register behind it.
// ----------------------------------------------------------------------------
module keypad_event_detector import kpd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	kpd_scan_if.sink            scan,
	kpd_result_if.source        result,
	input  logic                cfg_we,
	input  logic [LP_W-1:0]     cfg_wdata
);

	logic            accept;
	logic [LP_W-1:0] long_press_ms_q;
	kpd_key_evt_t    lane_evt [NUM_KEYS];
	kpd_knob_evt_t   knob_evt;
	kpd_result_t     merged;
	kpd_result_t     out_q;
	kpd_result_t     skid_q;
	logic            out_valid_q;
	logic            skid_valid_q;

	assign scan.ready = ~skid_valid_q;
	assign accept     = scan.valid & scan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_ms_q <= LONG_PRESS_RST;
		end else if (cfg_we) begin
			long_press_ms_q <= cfg_wdata;
		end
	end

	for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
		kpd_key_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (accept),
			.level  (scan.key_levels[i]),
			.evt    (lane_evt[i])
		);
	end

	kpd_knob u_knob (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (accept),
		.knob_level    (scan.knob_level),
		.now_ms        (scan.now_ms),
		.long_press_ms (long_press_ms_q),
		.evt           (knob_evt)
	);

	// merge lane findings; key bits beyond the lanes read as zero
	always_comb begin
		merged.keys_held     = '0;
		merged.keys_pressed  = '0;
		merged.keys_released = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			merged.keys_held[i]     = lane_evt[i].held;
			merged.keys_pressed[i]  = lane_evt[i].pressed;
			merged.keys_released[i] = lane_evt[i].released;
		end
		merged.short_press = knob_evt.short_press;
		merged.long_press  = knob_evt.long_press;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || result.ready) begin
			out_q <= skid_valid_q ? skid_q : merged;
		end else if (accept) begin
			skid_q <= merged;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.keys_held     = out_q.keys_held;
	assign result.keys_pressed  = out_q.keys_pressed;
	assign result.keys_released = out_q.keys_released;
	assign result.short_press   = out_q.short_press;
	assign result.long_press    = out_q.long_press;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without output entry");

	a_transfer_shows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result.valid)
		else $error("transferred scan left no result");

	a_knob_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.short_press && result.long_press))
		else $error("short and long press in one result");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && out_valid_q && !result.ready) |=> skid_valid_q)
		else $error("stalled transfer lost");
`endif

endmodule
